[rtl/core/psfc_pkg.sv]
// psfc_pkg: shared types, constants and helpers of the pcm sample format converter
// no dependencies; used by psfc_lane, psfc_merge and pcm_sample_format_converter_unit
package psfc_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgSrcIsSigned  = 3'd0;
  localparam logic [2:0] CfgSrcWidthCode = 3'd1;
  localparam logic [2:0] CfgSrcStereo    = 3'd2;
  localparam logic [2:0] CfgDstStereo    = 3'd3;
  localparam logic [2:0] CfgDstIs16bit   = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 2;

  // source width codes
  localparam logic [1:0] SrcWidth8  = 2'd0;
  localparam logic [1:0] SrcWidth16 = 2'd1;

  localparam logic [15:0] OffsetZero   = 16'h8000;  // 32768
  localparam logic [38:0] FloatScale   = 39'd32767;
  localparam logic [7:0]  ExpAllOnes   = 8'hFF;
  localparam logic [7:0]  ExpBinPoint  = 8'd150;    // 127 + 23
  localparam logic [7:0]  MaxShift     = 8'd40;     // any larger shift rounds to zero
  localparam logic [7:0]  Offset8Bias  = 8'h80;     // 128

  typedef struct packed {
    logic       src_is_signed;
    logic [1:0] src_width_code;
    logic       src_stereo;
    logic       dst_stereo;
    logic       dst_is_16bit;
  } psfc_cfg_t;

  // one decoded sample: value plus 32768, and the clamp flag
  typedef struct packed {
    logic [15:0] off;
    logic        sat;
  } psfc_lane_t;

  // offset sample to result encoding
  function automatic logic [15:0] encode(input logic [15:0] off, input logic dst16);
    logic [15:0] res;
    if (dst16) begin
      res = off ^ OffsetZero;
    end else begin
      res = {8'h00, off[15:8]};
    end
    return res;
  endfunction

endpackage

[rtl/core/psfc_lane.sv]
// psfc_lane: decodes one source sample (8/16-bit integer or float32) to offset-16 form
// two stages: scale multiply, then round, shift and clamp; uses psfc_pkg
module psfc_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en1_i,
  input  logic                  en2_i,
  input  psfc_pkg::psfc_cfg_t   cfg_i,
  input  logic [31:0]           word_i,
  output psfc_pkg::psfc_lane_t  res_o
);

  typedef struct packed {
    logic        is_float;
    logic        neg;
    logic        big;
    logic        zero;
    logic [38:0] prod;
    logic [5:0]  sh;
    logic [15:0] ioff;
  } lane_s1_t;

  lane_s1_t             s1_d, s1_q;
  psfc_pkg::psfc_lane_t res_d, res_q;

  logic [7:0]  exp_w;
  logic [22:0] frac_w;
  logic [23:0] mant;
  logic [7:0]  exp_eff;
  logic [7:0]  sh_full;
  logic [7:0]  byte_w;
  logic [39:0] rounded;
  logic        over;
  logic [15:0] mag;

  // stage 1: classify, scale by 32767, integer decode
  always_comb begin
    exp_w   = word_i[30:23];
    frac_w  = word_i[22:0];
    mant    = (exp_w == 8'h00) ? {1'b0, frac_w} : {1'b1, frac_w};
    exp_eff = (exp_w == 8'h00) ? 8'd1 : exp_w;
    sh_full = psfc_pkg::ExpBinPoint - exp_eff;
    byte_w  = word_i[7:0];

    s1_d.is_float = cfg_i.src_width_code[1];
    s1_d.neg      = word_i[31];
    // infinity or too large an exponent always clamps
    s1_d.big      = ((exp_w == psfc_pkg::ExpAllOnes) && (frac_w == '0)) ||
                    ((exp_w >= psfc_pkg::ExpBinPoint) && (exp_w != psfc_pkg::ExpAllOnes));
    // not a number, zero, or shifted out entirely
    s1_d.zero     = ((exp_w == psfc_pkg::ExpAllOnes) && (frac_w != '0)) ||
                    ((exp_w == 8'h00) && (frac_w == '0)) ||
                    ((exp_eff < psfc_pkg::ExpBinPoint) && (sh_full > psfc_pkg::MaxShift));
    s1_d.prod     = {15'd0, mant} * psfc_pkg::FloatScale;
    s1_d.sh       = sh_full[5:0];

    if (cfg_i.src_width_code == psfc_pkg::SrcWidth8) begin
      s1_d.ioff = cfg_i.src_is_signed ? {byte_w ^ psfc_pkg::Offset8Bias, 8'h00}
                                      : {byte_w, 8'h00};
    end else begin
      s1_d.ioff = cfg_i.src_is_signed ? (word_i[15:0] ^ psfc_pkg::OffsetZero)
                                      : word_i[15:0];
    end
  end

  // stage 2: round half away from zero, then clamp to 16 bits
  always_comb begin
    rounded = ({1'b0, s1_q.prod} + (40'd1 << (s1_q.sh - 6'd1))) >> s1_q.sh;
    if (s1_q.zero) begin
      rounded = '0;
    end
    over = s1_q.big || (|rounded[39:16]);
    mag  = rounded[15:0];

    if (!s1_q.is_float) begin
      res_d.off = s1_q.ioff;
      res_d.sat = 1'b0;
    end else if (s1_q.neg) begin
      res_d.sat = over || (mag > psfc_pkg::OffsetZero);
      res_d.off = res_d.sat ? 16'h0000 : (psfc_pkg::OffsetZero - mag);
    end else begin
      res_d.sat = over || (mag > (psfc_pkg::OffsetZero - 16'd1));
      res_d.off = res_d.sat ? 16'hFFFF : (psfc_pkg::OffsetZero + mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      s1_q <= s1_d;
    end
    if (en2_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // a float sample that gets rounded always has a shift of at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.is_float && !s1_q.big && !s1_q.zero |-> (s1_q.sh != 6'd0))
    else $error("float lane shift out of range");

endmodule

[rtl/core/psfc_merge.sv]
// psfc_merge: combines the two lane results into the result word (pass-through, stereo, mono mix)
// holds the output register; uses psfc_pkg
module psfc_merge (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  psfc_pkg::psfc_cfg_t   cfg_i,
  input  psfc_pkg::psfc_lane_t  left_i,
  input  psfc_pkg::psfc_lane_t  right_i,
  input  logic [15:0]           left_low_i,
  input  logic [15:0]           right_low_i,
  input  logic                  last_i,
  output logic [15:0]           left_out_o,
  output logic [15:0]           right_out_o,
  output logic                  right_valid_o,
  output logic                  saturated_o,
  output logic                  last_out_o
);

  logic [15:0] left_d, left_q, right_d, right_q;
  logic        rvalid_d, rvalid_q, sat_d, sat_q, last_q;
  logic        same_width;
  logic [15:0] roff;
  logic        rsat;
  logic [16:0] sum;

  always_comb begin
    same_width = ((cfg_i.src_width_code == psfc_pkg::SrcWidth8) && !cfg_i.dst_is_16bit) ||
                 ((cfg_i.src_width_code == psfc_pkg::SrcWidth16) && cfg_i.dst_is_16bit);
    // mono source reuses left for right
    roff = cfg_i.src_stereo ? right_i.off : left_i.off;
    rsat = cfg_i.src_stereo && right_i.sat;
    sum  = {1'b0, left_i.off} + {1'b0, roff};
    rvalid_d = cfg_i.dst_stereo;

    if (same_width && (cfg_i.src_stereo == cfg_i.dst_stereo)) begin
      left_d  = cfg_i.dst_is_16bit ? left_low_i : {8'h00, left_low_i[7:0]};
      right_d = !cfg_i.dst_stereo ? 16'h0000 :
                (cfg_i.dst_is_16bit ? right_low_i : {8'h00, right_low_i[7:0]});
      sat_d   = 1'b0;
    end else if (cfg_i.dst_stereo) begin
      left_d  = psfc_pkg::encode(left_i.off, cfg_i.dst_is_16bit);
      right_d = psfc_pkg::encode(roff, cfg_i.dst_is_16bit);
      sat_d   = left_i.sat || rsat;
    end else begin
      left_d  = psfc_pkg::encode(sum[16:1], cfg_i.dst_is_16bit);
      right_d = 16'h0000;
      sat_d   = left_i.sat || rsat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q   <= left_d;
      right_q  <= right_d;
      rvalid_q <= rvalid_d;
      sat_q    <= sat_d;
      last_q   <= last_i;
    end
  end

  assign left_out_o    = left_q;
  assign right_out_o   = right_q;
  assign right_valid_o = rvalid_q;
  assign saturated_o   = sat_q;
  assign last_out_o    = last_q;

endmodule

[rtl/core/pcm_sample_format_converter_unit.sv]
// pcm_sample_format_converter_unit: top level, config registers, pipeline control,
// two decode lanes and the merge stage; uses psfc_pkg, psfc_lane, psfc_merge
//
//  channel | handshake                    | payload
//  --------+------------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o      | left_raw_i, right_raw_i, last_frame_i
//  out     | out_valid_o / out_stall_i    | left_out_o, right_out_o, right_valid_o,
//          |                              | saturated_o, last_out_o
//  cfg     | cfg_we_i                     | cfg_idx_i, cfg_wdata_i
//
// three-stage pipeline: scale multiply, round/clamp in both lanes, merge into the output
// register; one word is taken every cycle unless the output stall has backed up to the input
// the float lane's 24x15 multiply and 40-bit round/shift set the stage split
// reset clears the valid bits and loads the register defaults (16-bit signed mono in and out)
// a stalled output backs up through full stages only; bubbles are filled while stalled
module pcm_sample_format_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psfc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   left_raw_i,
  input  logic [31:0]                   right_raw_i,
  input  logic                          last_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   left_out_o,
  output logic [15:0]                   right_out_o,
  output logic                          right_valid_o,
  output logic                          saturated_o,
  output logic                          last_out_o
);

  psfc_pkg::psfc_cfg_t  cfg_q, cfg_d;
  psfc_pkg::psfc_lane_t left_res, right_res;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic [15:0] llow1_q, llow2_q, rlow1_q, rlow2_q;
  logic        last1_q, last2_q;

  // config registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        psfc_pkg::CfgSrcIsSigned:  cfg_d.src_is_signed  = cfg_wdata_i[0];
        psfc_pkg::CfgSrcWidthCode: cfg_d.src_width_code = cfg_wdata_i[1:0];
        psfc_pkg::CfgSrcStereo:    cfg_d.src_stereo     = cfg_wdata_i[0];
        psfc_pkg::CfgDstStereo:    cfg_d.dst_stereo     = cfg_wdata_i[0];
        psfc_pkg::CfgDstIs16bit:   cfg_d.dst_is_16bit   = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_is_signed  <= 1'b1;
      cfg_q.src_width_code <= psfc_pkg::SrcWidth16;
      cfg_q.src_stereo     <= 1'b0;
      cfg_q.dst_stereo     <= 1'b0;
      cfg_q.dst_is_16bit   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // a stage loads when it is empty or its word moves on
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // raw low halves and packet mark ride alongside the lanes
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      llow1_q <= left_raw_i[15:0];
      rlow1_q <= right_raw_i[15:0];
      last1_q <= last_frame_i;
    end
    if (rdy2) begin
      llow2_q <= llow1_q;
      rlow2_q <= rlow1_q;
      last2_q <= last1_q;
    end
  end

  psfc_lane u_lane_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en1_i  (rdy1),
    .en2_i  (rdy2),
    .cfg_i  (cfg_q),
    .word_i (left_raw_i),
    .res_o  (left_res)
  );

  psfc_lane u_lane_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en1_i  (rdy1),
    .en2_i  (rdy2),
    .cfg_i  (cfg_q),
    .word_i (right_raw_i),
    .res_o  (right_res)
  );

  psfc_merge u_merge (
    .clk_i         (clk_i),
    .en_i          (rdy3),
    .cfg_i         (cfg_q),
    .left_i        (left_res),
    .right_i       (right_res),
    .left_low_i    (llow2_q),
    .right_low_i   (rlow2_q),
    .last_i        (last2_q),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .right_valid_o (right_valid_o),
    .saturated_o   (saturated_o),
    .last_out_o    (last_out_o)
  );

  assign out_valid_o = v3_q;

  // input only stalls when every stage holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with an empty stage");

  // an accepted word lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted word lost at stage one");

  // mono results carry no right sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !right_valid_o) |-> (right_out_o == 16'h0000))
    else $error("right sample present in mono result");

  // clamping only comes from a float source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> cfg_q.src_width_code[1])
    else $error("saturation flagged for an integer source");

endmodule

[test/pcm_sample_format_converter_unit_test.sv]
// pcm_sample_format_converter_unit_test: self-checking bench for the pcm format converter,
// directed corner frames then random frames over every register setting, with backpressure
// depends on psfc_pkg and pcm_sample_format_converter_unit
module pcm_sample_format_converter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkPeriod      = 8;
  localparam int          LatencyCycles  = 3;
  localparam int          LongHoldCycles = 40;
  localparam int          FramesPerSetup = 16;
  localparam int          CycleLimit     = 200000;
  localparam logic [1:0]  SrcWidthFloat  = 2'd2;
  localparam logic [1:0]  SrcWidthAlt    = 2'd3;  // also decoded as float32

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        right_vld;
    logic        sat;
    logic        last;
  } pcm_frame_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [psfc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [psfc_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [31:0]                   left_raw_i;
  logic [31:0]                   right_raw_i;
  logic                          last_frame_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [15:0]                   left_out_o;
  logic [15:0]                   right_out_o;
  logic                          right_valid_o;
  logic                          saturated_o;
  logic                          last_out_o;

  psfc_pkg::psfc_cfg_t fmt;
  pcm_frame_t          expected_frames[$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  bit                  src_idles = 1'b1;
  bit                  rx_idles = 1'b1;
  bit                  long_hold_req = 1'b0;

  pcm_sample_format_converter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .left_raw_i    (left_raw_i),
    .right_raw_i   (right_raw_i),
    .last_frame_i  (last_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .right_valid_o (right_valid_o),
    .saturated_o   (saturated_o),
    .last_out_o    (last_out_o)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // float32 times 32767, rounded half away from zero, clamped, as offset binary
  function automatic psfc_pkg::psfc_lane_t float_to_offset(input logic [31:0] w);
    logic                 neg;
    logic [7:0]           e;
    logic [22:0]          frac;
    logic [63:0]          m;
    logic [63:0]          p;
    logic [63:0]          mag;
    logic [63:0]          diff;
    int unsigned          ee;
    int unsigned          sh;
    psfc_pkg::psfc_lane_t r;
    neg = w[31];
    e = w[30:23];
    frac = w[22:0];
    r.sat = 1'b0;
    if (e == 8'hFF) begin
      // nan reads as zero, infinity clamps
      if (frac != 23'd0) begin
        r.off = psfc_pkg::OffsetZero;
      end else begin
        r.sat = 1'b1;
        r.off = neg ? 16'h0000 : 16'hFFFF;
      end
      return r;
    end
    m = (e == 8'd0) ? {41'd0, frac} : {40'd0, 1'b1, frac};
    ee = (e == 8'd0) ? 1 : e;
    p = m * 64'd32767;
    if (p == 64'd0) begin
      mag = 64'd0;
    end else if (ee >= 150) begin
      mag = 64'h10000;
    end else begin
      sh = 150 - ee;
      if (sh > 62) begin
        mag = 64'd0;
      end else begin
        mag = (p + (64'd1 << (sh - 1))) >> sh;
      end
    end
    if (neg) begin
      if (mag > 64'd32768) begin
        r.sat = 1'b1;
        r.off = 16'h0000;
      end else begin
        diff = 64'd32768 - mag;
        r.off = diff[15:0];
      end
    end else if (mag > 64'd32767) begin
      r.sat = 1'b1;
      r.off = 16'hFFFF;
    end else begin
      diff = 64'd32768 + mag;
      r.off = diff[15:0];
    end
    return r;
  endfunction

  function automatic psfc_pkg::psfc_lane_t sample_to_offset(input logic [31:0] w);
    psfc_pkg::psfc_lane_t r;
    r.sat = 1'b0;
    if (fmt.src_width_code == psfc_pkg::SrcWidth8) begin
      r.off = fmt.src_is_signed ? {w[7:0] ^ 8'h80, 8'h00} : {w[7:0], 8'h00};
    end else if (fmt.src_width_code == psfc_pkg::SrcWidth16) begin
      r.off = fmt.src_is_signed ? (w[15:0] ^ psfc_pkg::OffsetZero) : w[15:0];
    end else begin
      r = float_to_offset(w);
    end
    return r;
  endfunction

  function automatic logic [15:0] offset_to_pcm(input logic [15:0] off);
    return fmt.dst_is_16bit ? (off ^ psfc_pkg::OffsetZero) : {8'h00, off[15:8]};
  endfunction

  function automatic pcm_frame_t convert_frame(input logic [31:0] lw, input logic [31:0] rw,
                                               input logic last);
    pcm_frame_t           res;
    psfc_pkg::psfc_lane_t l;
    psfc_pkg::psfc_lane_t r;
    logic [16:0]          sum;
    logic [15:0]          mask;
    bit                   same_width;
    same_width = (fmt.src_width_code == psfc_pkg::SrcWidth8 && !fmt.dst_is_16bit) ||
                 (fmt.src_width_code == psfc_pkg::SrcWidth16 && fmt.dst_is_16bit);
    res.right_vld = fmt.dst_stereo;
    res.last = last;
    if (same_width && fmt.src_stereo == fmt.dst_stereo) begin
      mask = fmt.dst_is_16bit ? 16'hFFFF : 16'h00FF;
      res.left = lw[15:0] & mask;
      res.right = fmt.dst_stereo ? (rw[15:0] & mask) : 16'h0000;
      res.sat = 1'b0;
      return res;
    end
    l = sample_to_offset(lw);
    // mono source: right copies left and its flag is never raised
    if (fmt.src_stereo) begin
      r = sample_to_offset(rw);
    end else begin
      r.off = l.off;
      r.sat = 1'b0;
    end
    res.sat = l.sat | r.sat;
    if (fmt.dst_stereo) begin
      res.left = offset_to_pcm(l.off);
      res.right = offset_to_pcm(r.off);
    end else begin
      sum = {1'b0, l.off} + {1'b0, r.off};
      res.left = offset_to_pcm(sum[16:1]);
      res.right = 16'h0000;
    end
    return res;
  endfunction

  task automatic write_reg(input logic [psfc_pkg::CfgIdxW-1:0] idx,
                           input logic [psfc_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      psfc_pkg::CfgSrcIsSigned:  fmt.src_is_signed = val[0];
      psfc_pkg::CfgSrcWidthCode: fmt.src_width_code = val;
      psfc_pkg::CfgSrcStereo:    fmt.src_stereo = val[0];
      psfc_pkg::CfgDstStereo:    fmt.dst_stereo = val[0];
      psfc_pkg::CfgDstIs16bit:   fmt.dst_is_16bit = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 2) @(posedge clk_i);
  endtask

  task automatic set_format(input logic sgn, input logic [1:0] code, input logic src_st,
                            input logic dst_st, input logic dst16);
    wait_drained();
    write_reg(psfc_pkg::CfgSrcIsSigned, {1'b0, sgn});
    write_reg(psfc_pkg::CfgSrcWidthCode, code);
    write_reg(psfc_pkg::CfgSrcStereo, {1'b0, src_st});
    write_reg(psfc_pkg::CfgDstStereo, {1'b0, dst_st});
    write_reg(psfc_pkg::CfgDstIs16bit, {1'b0, dst16});
  endtask

  task automatic send_frame(input logic [31:0] lw, input logic [31:0] rw, input logic last);
    int gap;
    @(negedge clk_i);
    if (src_idles && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_raw_i <= lw;
    right_raw_i <= rw;
    last_frame_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_frames.push_back(convert_frame(lw, rw, last));
  endtask

  function automatic logic [31:0] rand_int_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[15:0] = 16'h0000;
      1: w[15:0] = 16'h7FFF;
      2: w[15:0] = 16'h8000;
      3: w[15:0] = 16'hFFFF;
      4: w[7:0] = 8'h7F;
      5: w[7:0] = 8'h80;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_float_word();
    logic        s;
    logic [7:0]  e;
    logic [31:0] fr;
    s = 1'($urandom_range(0, 1));
    fr = $urandom;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: e = 8'd0;
      2: begin
        e = 8'hFF;
        if ($urandom_range(0, 1) == 1) fr = 32'd0;
      end
      3: begin
        // just above one, where clamping starts
        e = 8'd127;
        fr = fr & 32'h0000_03FF;
      end
      4: e = 8'd126;
      default: e = 8'($urandom_range(100, 142));
    endcase
    return {s, e, fr[22:0]};
  endfunction

  function automatic logic [31:0] rand_word();
    return (fmt.src_width_code >= SrcWidthFloat) ? rand_float_word() : rand_int_word();
  endfunction

  function automatic logic rand_last();
    return 1'($urandom_range(0, 1));
  endfunction

  // receiver: random stall bursts, or one long hold when asked for
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_idles && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 5);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pcm_frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        $error("output word with nothing expected: left_out %h right_out %h",
               left_out_o, right_out_o);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (left_out_o !== want.left) begin
          $error("left_out: expected %h, got %h", want.left, left_out_o);
          error_count++;
        end
        if (right_out_o !== want.right) begin
          $error("right_out: expected %h, got %h", want.right, right_out_o);
          error_count++;
        end
        if (right_valid_o !== want.right_vld) begin
          $error("right_valid: expected %b, got %b", want.right_vld, right_valid_o);
          error_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated_o);
          error_count++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, last_out_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // reset format is 16-bit mono to 16-bit mono, a straight copy
  task automatic test_reset_format();
    send_frame(32'hFFFF_8001, 32'h1234_5678, 1'b1);
    send_frame(32'h0000_7FFF, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_integer_extremes();
    set_format(1'b0, psfc_pkg::SrcWidth8, 1'b1, 1'b1, 1'b1);
    send_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_frame(32'hFFFF_FF80, 32'h0000_007F, 1'b1);
    set_format(1'b1, psfc_pkg::SrcWidth8, 1'b0, 1'b0, 1'b0);
    send_frame(32'h5A5A_5AA5, 32'hFFFF_FFFF, 1'b1);
    set_format(1'b0, psfc_pkg::SrcWidth16, 1'b1, 1'b0, 1'b0);
    send_frame(32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    send_frame(32'h0000_8000, 32'h0000_7FFF, 1'b1);
    set_format(1'b1, psfc_pkg::SrcWidth16, 1'b1, 1'b0, 1'b1);
    send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    set_format(1'b1, psfc_pkg::SrcWidth8, 1'b1, 1'b1, 1'b0);
    send_frame(32'h1234_5680, 32'hABCD_EF7F, 1'b0);
  endtask

  task automatic test_float_special_values();
    set_format(1'b1, SrcWidthFloat, 1'b1, 1'b1, 1'b1);
    send_frame(32'h3F00_0000, 32'hBF00_0000, 1'b0);  // half: ties round away
    send_frame(32'h3F80_0000, 32'hBF80_0000, 1'b0);
    send_frame(32'h7F80_0000, 32'hFF80_0000, 1'b1);  // infinities
    send_frame(32'h7FC0_0000, 32'hFFFF_FFFF, 1'b0);  // nans
    send_frame(32'h0000_0001, 32'h7F7F_FFFF, 1'b0);  // denormal, largest normal
    send_frame(32'h3F80_0100, 32'hBF80_0100, 1'b1);  // just past +max, exactly -32768
    send_frame(32'hBF80_0200, 32'h8000_0000, 1'b0);
    // width code three, mono: the right word is ignored even when it would clamp
    set_format(1'b0, SrcWidthAlt, 1'b0, 1'b1, 1'b0);
    send_frame(32'h3F00_0000, 32'hFF80_0000, 1'b1);
    send_frame(32'h7F80_0000, 32'h0000_0000, 1'b0);
    set_format(1'b1, SrcWidthFloat, 1'b1, 1'b0, 1'b1);
    send_frame(32'h7F80_0000, 32'hFF80_0000, 1'b1);
  endtask

  task automatic test_backpressure();
    int k;
    set_format(1'b1, SrcWidthFloat, 1'b1, 1'b0, 1'b0);
    src_idles = 1'b0;
    long_hold_req = 1'b1;
    for (k = 0; k < 30; k++) begin
      send_frame(rand_word(), rand_word(), rand_last());
    end
    // sender waits for the pipe to empty before going on
    wait_drained();
    src_idles = 1'b1;
  endtask

  task automatic test_random_formats();
    int          c;
    int          k;
    logic [5:0]  f;
    bit          quiet;
    for (c = 0; c < 64; c++) begin
      f = c[5:0];
      set_format(f[0], f[2:1], f[3], f[4], f[5]);
      // the last setups and a random share run without any idling
      quiet = (c >= 56) || ($urandom_range(0, 3) == 0);
      src_idles = !quiet;
      rx_idles = !quiet;
      for (k = 0; k < FramesPerSetup; k++) begin
        send_frame(rand_word(), rand_word(), rand_last());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    left_raw_i = '0;
    right_raw_i = '0;
    last_frame_i = 1'b0;
    fmt.src_is_signed = 1'b1;
    fmt.src_width_code = psfc_pkg::SrcWidth16;
    fmt.src_stereo = 1'b0;
    fmt.dst_stereo = 1'b0;
    fmt.dst_is_16bit = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_format();
    test_integer_extremes();
    test_float_special_values();
    test_backpressure();
    test_random_formats();
    wait_drained();

    if (error_count == 0 && expected_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/psfc_pkg.sv
rtl/core/psfc_lane.sv
rtl/core/psfc_merge.sv
rtl/core/pcm_sample_format_converter_unit.sv
test/pcm_sample_format_converter_unit_test.sv
